// ----- rtl/lsse_pkg.sv -----
// Shared types and constants for the line-sensor steering error block.
package lsse_pkg;

  localparam int unsigned SENSOR_COUNT  = 8;
  localparam int unsigned FRACTION_BITS = 8;

  // Shift that turns a count of half units into fixed point.
  localparam int unsigned HALF_SHIFT = FRACTION_BITS - 1;

  localparam int unsigned IDX_W    = $clog2(SENSOR_COUNT);
  localparam int unsigned CNT_W    = $clog2(SENSOR_COUNT + 1);
  localparam int unsigned SUM_W    = 6;   // sums of half-unit positions, -19 .. 19
  localparam int unsigned MAG_W    = 5;   // magnitude of such a sum
  localparam int unsigned DVD_W    = MAG_W + HALF_SHIFT;
  localparam int unsigned REM_W    = CNT_W + 1;
  localparam int unsigned ITER_W   = $clog2(DVD_W);
  localparam int unsigned POS_W    = 11;  // magnitude of a position, up to 4.5
  localparam int unsigned GAIN_W   = 9;
  localparam int unsigned PROD_W   = POS_W + GAIN_W;
  localparam int unsigned OUT_W    = 12;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ADDR_W   = 3;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 9'd205;
  localparam logic [DVD_W-1:0]  LOST_MAG   = DVD_W'(9) << HALF_SHIFT;
  localparam logic [OUT_W-1:0]  OUT_MAX    = 12'h7ff;
  localparam logic [OUT_W-1:0]  OUT_MIN    = 12'h800;

  // Register index of the gain, taken from the word address.
  localparam logic REG_STEER_GAIN = 1'b0;

  // Sensor positions in half units, sensor 0 leftmost.
  localparam logic signed [SUM_W-1:0] SENSOR_HALF [SENSOR_COUNT] = '{
    -6'sd9, -6'sd6, -6'sd3, -6'sd1, 6'sd1, 6'sd3, 6'sd6, 6'sd9
  };

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_POS  = 2'd1,
    DIR_NEG  = 2'd2
  } dir_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_SETUP,
    ST_DIVIDE,
    ST_MULT,
    ST_DONE
  } state_e;

endpackage

// ----- rtl/line_sensor_steer_error.sv -----
// Top level of the line-sensor steering error block.
//
// One input beat carries an 8-bit sensor bitmap on sensor_bits_i; each beat
// produces exactly one output beat with the steering value, the line position
// before scaling, and a flag that tells whether the line was lost.
// A beat moves at a rising edge where valid is high and stall is low.
// The work runs on a small sequencer: it sums the active positions and counts
// them one sensor at a time, takes a setup step, runs a restoring divider that
// yields one quotient bit per cycle, forms the gain product, and then
// saturates the result and loads the output register; a lost line skips the
// divider. The block takes no new item until it is done with the last one,
// and in_stall_o stays high while it is busy.
// The output register holds the finished beat while the receiver stalls, and
// a new input beat is taken meanwhile; the sequencer waits at its last step
// only if the previous output has still not been taken.
// Reset clears the sequencer, the output valid flag and the remembered line
// direction, and loads the gain register with 205 (about 0.8).
// The gain is written through the APB port at byte address 0.
module line_sensor_steer_error
  import lsse_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Input channel.
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [7:0]              sensor_bits_i,
  // Output channel.
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [OUT_W-1:0] steer_value_o,
  output logic signed [OUT_W-1:0] position_o,
  output logic                    line_lost_o,
  // Configuration port.
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready
);

  state_e state_q, state_d;
  dir_e   dir_q, dir_d;
  logic   out_valid_q, out_valid_d;
  logic [GAIN_W-1:0] gain_q;

  // Datapath registers.
  logic [SENSOR_COUNT-1:0] bits_q, bits_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [DVD_W-1:0]        dvd_q, dvd_d;
  logic [REM_W-1:0]        rem_q, rem_d;
  logic [ITER_W-1:0]       iter_q, iter_d;
  logic                    neg_q, neg_d;
  logic                    lost_q, lost_d;
  logic [PROD_W-1:0]       prod_q, prod_d;
  logic signed [OUT_W-1:0] steer_q, steer_d;
  logic signed [OUT_W-1:0] pos_q, pos_d;
  logic                    line_lost_q, line_lost_d;

  logic              in_accept;
  logic              cfg_write;
  logic [MAG_W-1:0]  abs_sum;
  logic [REM_W-1:0]  rem_shift;
  logic              rem_fits;
  logic [OUT_W-1:0]  steer_mag;
  logic [POS_W-1:0]  pos_mag;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // The register is selected by the word address; pready is tied high, so a
  // write completes in its access cycle.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_STEER_GAIN) ? DATA_W'(gain_q) : '0;

  assign out_valid_o   = out_valid_q;
  assign steer_value_o = steer_q;
  assign position_o    = pos_q;
  assign line_lost_o   = line_lost_q;

  // Shared pieces of the datapath.
  assign abs_sum   = sum_q[SUM_W-1] ? MAG_W'(-sum_q) : MAG_W'(sum_q);
  assign rem_shift = {rem_q[REM_W-2:0], dvd_q[DVD_W-1]};
  assign rem_fits  = (rem_shift >= REM_W'(count_q));
  assign steer_mag = prod_q[PROD_W-1:PROD_W-OUT_W];
  assign pos_mag   = dvd_q[POS_W-1:0];

  always_comb begin
    state_d     = state_q;
    dir_d       = dir_q;
    out_valid_d = out_valid_q;
    bits_d      = bits_q;
    idx_d       = idx_q;
    sum_d       = sum_q;
    count_d     = count_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    iter_d      = iter_q;
    neg_d       = neg_q;
    lost_d      = lost_q;
    prod_d      = prod_q;
    steer_d     = steer_q;
    pos_d       = pos_q;
    line_lost_d = line_lost_q;

    // The receiver takes the pending output beat.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          bits_d  = sensor_bits_i[SENSOR_COUNT-1:0];
          idx_d   = '0;
          sum_d   = '0;
          count_d = '0;
          state_d = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        // One sensor a cycle through the adder.
        if (bits_q[idx_q]) begin
          sum_d   = sum_q + SENSOR_HALF[idx_q];
          count_d = count_q + CNT_W'(1);
        end
        idx_d = idx_q + IDX_W'(1);
        if (idx_q == IDX_W'(SENSOR_COUNT - 1)) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        rem_d  = '0;
        iter_d = '0;
        if (count_q == '0) begin
          // Line lost: steer hard away from the side it was last seen on, or straight if no side is remembered.
          lost_d = 1'b1;
          case (dir_q)
            DIR_POS: begin
              dvd_d = LOST_MAG;
              neg_d = 1'b1;
            end
            DIR_NEG: begin
              dvd_d = LOST_MAG;
              neg_d = 1'b0;
            end
            default: begin
              dvd_d = '0;
              neg_d = 1'b0;
            end
          endcase
          state_d = ST_MULT;
        end else begin
          lost_d  = 1'b0;
          neg_d   = sum_q[SUM_W-1];
          dvd_d   = DVD_W'(abs_sum) << HALF_SHIFT;
          state_d = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        // Restoring division, one quotient bit a cycle; the quotient
        // shifts into the dividend register from the bottom.
        rem_d  = rem_fits ? (rem_shift - REM_W'(count_q)) : rem_shift;
        dvd_d  = {dvd_q[DVD_W-2:0], rem_fits};
        iter_d = iter_q + ITER_W'(1);
        if (iter_q == ITER_W'(DVD_W - 1)) begin
          state_d = ST_MULT;
        end
      end
      ST_MULT: begin
        prod_d = PROD_W'(pos_mag) * PROD_W'(gain_q);
        if (!lost_q) begin
          if (pos_mag == '0) begin
            dir_d = DIR_NONE;
          end else if (neg_q) begin
            dir_d = DIR_NEG;
          end else begin
            dir_d = DIR_POS;
          end
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          if (neg_q) begin
            steer_d = (steer_mag > OUT_MIN) ? OUT_MIN : -steer_mag;
            pos_d   = -OUT_W'(pos_mag);
          end else begin
            steer_d = (steer_mag > OUT_MAX) ? OUT_MAX : steer_mag;
            pos_d   = OUT_W'(pos_mag);
          end
          line_lost_d = lost_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dir_q       <= DIR_NONE;
      out_valid_q <= 1'b0;
      gain_q      <= GAIN_RESET;
    end else begin
      state_q     <= state_d;
      dir_q       <= dir_d;
      out_valid_q <= out_valid_d;
      if (cfg_write && (paddr[2] == REG_STEER_GAIN)) begin
        gain_q <= pwdata[GAIN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q      <= bits_d;
    idx_q       <= idx_d;
    sum_q       <= sum_d;
    count_q     <= count_d;
    dvd_q       <= dvd_d;
    rem_q       <= rem_d;
    iter_q      <= iter_d;
    neg_q       <= neg_d;
    lost_q      <= lost_d;
    prod_q      <= prod_d;
    steer_q     <= steer_d;
    pos_q       <= pos_d;
    line_lost_q <= line_lost_d;
  end

  // An accepted item keeps the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("block not busy after an accepted item");

  // A lost line reports a position of zero or a full deflection.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && line_lost_o) |->
      (position_o == 12'sd0 || position_o == 12'sd1152 || position_o == -12'sd1152))
    else $error("lost line with an unexpected position");

  // Scaling by an unsigned gain never flips the sign.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (position_o >= 12'sd0)) |-> (steer_value_o >= 12'sd0))
    else $error("steering value sign differs from position");

  // The active count never exceeds the number of sensors.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SETUP) |-> (count_q <= CNT_W'(SENSOR_COUNT)))
    else $error("active sensor count out of range");

endmodule
